[design/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the stick command conditioner
// Field widths, stick offsets and spans, reciprocal constants for the
// divisions by fixed spans, register indexes and the record types that
// travel between the front, the queue and the back.
// ----------------------------------------------------------------------------
package scc_pkg;

   localparam int ADC_FULL_SCALE = 4095;

   localparam int RAW_W      = 12;
   localparam int FULL_W     = 10;
   localparam int DB_W       = 8;
   localparam int ANGLE_W    = 7;
   localparam int PROD_W     = RAW_W + FULL_W + 1;
   localparam int QUOT_W     = FULL_W + 1;
   localparam int STEP_W     = QUOT_W + 1;
   localparam int CMD_W      = 11;
   localparam int THR_CMD_W  = 10;
   localparam int MILLI_W    = 20;
   localparam int SUM_W      = MILLI_W + 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // throttle offset held in hundredths, the others in whole counts
   localparam int HUND         = 100;
   localparam int THR_OFS_HUND = 15795;
   localparam int YAW_OFS      = 128;
   localparam int PITCH_OFS    = 150;
   localparam int ROLL_OFS     = 142;

   localparam int THR_HI_HUND = ADC_FULL_SCALE * HUND - THR_OFS_HUND;
   localparam int THR_SPAN    = THR_HI_HUND / HUND - THR_OFS_HUND / HUND;
   localparam int YAW_SPAN    = ADC_FULL_SCALE - 2 * YAW_OFS;
   localparam int PITCH_SPAN  = ADC_FULL_SCALE - 2 * PITCH_OFS;
   localparam int ROLL_SPAN   = ADC_FULL_SCALE - 2 * ROLL_OFS;

   // floor(n / span) = (n * ceil(2^k / span)) >> k for every n below 2^PROD_W
   localparam int RECIP_SHIFT = PROD_W + RAW_W;
   localparam int RECIP_W     = RECIP_SHIFT - RAW_W + 2;
   localparam int MUL_W       = PROD_W + RECIP_W;

   localparam logic [RECIP_W-1:0] THR_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + THR_SPAN - 1) / THR_SPAN);
   localparam logic [RECIP_W-1:0] YAW_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + YAW_SPAN - 1) / YAW_SPAN);
   localparam logic [RECIP_W-1:0] PITCH_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + PITCH_SPAN - 1) / PITCH_SPAN);
   localparam logic [RECIP_W-1:0] ROLL_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + ROLL_SPAN - 1) / ROLL_SPAN);

   // thousandths to whole units
   localparam int MILLI_PER_UNIT = 1000;
   localparam int THOU_SHIFT     = MILLI_W + 10;
   localparam int THOU_W         = THOU_SHIFT - 10 + 1;
   localparam int THOU_MUL_W     = MILLI_W + THOU_W;
   localparam logic [THOU_W-1:0] THOU_RECIP =
      THOU_W'(((64'd1 << THOU_SHIFT) + MILLI_PER_UNIT - 1) / MILLI_PER_UNIT);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_THROTTLE_STEP_MAX = 3'd0,
      REG_THROTTLE_DEADBAND = 3'd1,
      REG_THROTTLE_LIMIT    = 3'd2,
      REG_YAW_RATE_MAX      = 3'd3,
      REG_ROLL_RATE_MAX     = 3'd4,
      REG_ROLL_ANGLE_MAX    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [FULL_W-1:0]  throttle_step_max;
      logic [DB_W-1:0]    throttle_deadband;
      logic [FULL_W-1:0]  throttle_limit;
      logic [FULL_W-1:0]  yaw_rate_max;
      logic [FULL_W-1:0]  roll_rate_max;
      logic [ANGLE_W-1:0] roll_angle_max;
   } cfg_type;

   typedef struct packed {
      logic [PROD_W-1:0] thr_n;
      logic [PROD_W-1:0] yaw_n;
      logic [PROD_W-1:0] pitch_n;
      logic [PROD_W-1:0] roll_n;
      logic              gyro;
   } entry_type;

   typedef struct packed {
      logic gyro;
      logic button_last;
   } front_status_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   localparam logic [FULL_W-1:0]  RST_THROTTLE_STEP_MAX = 10'd230;
   localparam logic [DB_W-1:0]    RST_THROTTLE_DEADBAND = 8'd7;
   localparam logic [FULL_W-1:0]  RST_THROTTLE_LIMIT    = 10'd1000;
   localparam logic [FULL_W-1:0]  RST_YAW_RATE_MAX      = 10'd360;
   localparam logic [FULL_W-1:0]  RST_ROLL_RATE_MAX     = 10'd360;
   localparam logic [ANGLE_W-1:0] RST_ROLL_ANGLE_MAX    = 7'd15;

   function automatic logic [FULL_W-1:0] attitude_scale(cfg_type cfg, logic gyro);
      return gyro ? cfg.roll_rate_max : {{(FULL_W - ANGLE_W){1'b0}}, cfg.roll_angle_max};
   endfunction

endpackage

[design/scc_front.sv]
// ----------------------------------------------------------------------------
// scc_front: sample intake
// Clamps each stick sample onto its span, forms the scaled numerators and
// tracks the mode button, toggling gyro mode on a confirmed press.
// ----------------------------------------------------------------------------
module scc_front
   import scc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               accept,
   input  logic [RAW_W-1:0]   throttle_stick,
   input  logic [RAW_W-1:0]   yaw_stick,
   input  logic [RAW_W-1:0]   pitch_stick,
   input  logic [RAW_W-1:0]   roll_stick,
   input  logic               button_first,
   input  logic               button_recheck,
   output entry_type          entry,
   output front_status_type   status
);

   logic             button_last_ff, button_last_in;
   logic             mode_ff, mode_in;
   logic [RAW_W-1:0] thr_d, yaw_d, pitch_d, roll_d;
   logic [FULL_W-1:0] att_full;
   logic             press;

   always_ff @(posedge clock) begin
      if (reset) begin
         button_last_ff <= 1'b1;
         mode_ff        <= 1'b0;
      end else if (accept) begin
         button_last_ff <= button_last_in;
         mode_ff        <= mode_in;
      end
   end

   always_comb begin
      press          = !button_first && button_last_ff;
      button_last_in = press ? button_recheck : button_first;
      mode_in        = mode_ff ^ (press && !button_recheck);
   end

   always_comb begin
      thr_d   = (throttle_stick > RAW_W'(THR_SPAN))   ? RAW_W'(THR_SPAN)   : throttle_stick;
      yaw_d   = (yaw_stick      > RAW_W'(YAW_SPAN))   ? RAW_W'(YAW_SPAN)   : yaw_stick;
      pitch_d = (pitch_stick    > RAW_W'(PITCH_SPAN)) ? RAW_W'(PITCH_SPAN) : pitch_stick;
      roll_d  = (roll_stick     > RAW_W'(ROLL_SPAN))  ? RAW_W'(ROLL_SPAN)  : roll_stick;
      att_full = attitude_scale(cfg, mode_in);

      entry.thr_n   = PROD_W'(thr_d)   * PROD_W'({cfg.throttle_step_max, 1'b0});
      entry.yaw_n   = PROD_W'(yaw_d)   * PROD_W'({cfg.yaw_rate_max, 1'b0});
      entry.pitch_n = PROD_W'(pitch_d) * PROD_W'({att_full, 1'b0});
      entry.roll_n  = PROD_W'(roll_d)  * PROD_W'({att_full, 1'b0});
      entry.gyro    = mode_in;
   end

   assign status.gyro        = mode_ff;
   assign status.button_last = button_last_ff;

endmodule

[design/scc_queue.sv]
// ----------------------------------------------------------------------------
// scc_queue: short queue between front and back
// Holds classified items so that the intake and the command pipeline
// stall independently. Depth is a power of two.
// ----------------------------------------------------------------------------
module scc_queue
   import scc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type status
);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   assign pop_entry    = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

[design/scc_back.sv]
// ----------------------------------------------------------------------------
// scc_back: command pipeline
// Three stages: reciprocal division by the fixed spans, offset removal
// with throttle deadband and accumulate, then whole-unit throttle and the
// result register.
// ----------------------------------------------------------------------------
module scc_back
   import scc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       q_valid,
   input  entry_type                  q_entry,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [THR_CMD_W-1:0]       rsp_throttle_cmd,
   output logic signed [CMD_W-1:0]    rsp_yaw_cmd,
   output logic signed [CMD_W-1:0]    rsp_pitch_cmd,
   output logic signed [CMD_W-1:0]    rsp_roll_cmd,
   output logic                       rsp_gyro_mode
);

   logic ready1, ready2, ready3, load2, load3;

   logic              s1_valid_ff, s1_valid_in;
   logic [QUOT_W-1:0] s1_thr_ff, s1_yaw_ff, s1_pitch_ff, s1_roll_ff;
   logic [QUOT_W-1:0] s1_thr_in, s1_yaw_in, s1_pitch_in, s1_roll_in;
   logic              s1_gyro_ff;
   logic [MUL_W-1:0]  thr_mul, yaw_mul, pitch_mul, roll_mul;

   logic                     s2_valid_ff, s2_valid_in;
   logic signed [CMD_W-1:0]  s2_yaw_ff, s2_pitch_ff, s2_roll_ff;
   logic signed [CMD_W-1:0]  s2_yaw_in, s2_pitch_in, s2_roll_in;
   logic [MILLI_W-1:0]       s2_milli_ff;
   logic                     s2_gyro_ff;
   logic [MILLI_W-1:0]       milli_ff, milli_in;
   logic signed [STEP_W-1:0] thr_step, yaw_step, pitch_step, roll_step, thr_mag;
   logic signed [SUM_W-1:0]  sum;
   logic [MILLI_W-1:0]       lim_milli;
   logic [FULL_W-1:0]        att_full;

   logic                  s3_valid_ff, s3_valid_in;
   logic [THR_CMD_W-1:0]  s3_thr_ff, s3_thr_in;
   logic signed [CMD_W-1:0] s3_yaw_ff, s3_pitch_ff, s3_roll_ff;
   logic                  s3_gyro_ff;
   logic [THOU_MUL_W-1:0] thou_mul;

   always_comb begin
      ready3 = !s3_valid_ff || !rsp_stall;
      ready2 = !s2_valid_ff || ready3;
      ready1 = !s1_valid_ff || ready2;
      q_pop  = q_valid && ready1;
      load2  = s1_valid_ff && ready2;
      load3  = s2_valid_ff && ready3;

      s1_valid_in = q_pop  || (s1_valid_ff && !ready2);
      s2_valid_in = load2  || (s2_valid_ff && !ready3);
      s3_valid_in = load3  || (s3_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         milli_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         if (load2) begin
            milli_ff <= milli_in;
         end
      end
   end

   // stage 1: divide the numerators by the fixed spans
   always_comb begin
      thr_mul   = MUL_W'(q_entry.thr_n)   * MUL_W'(THR_RECIP);
      yaw_mul   = MUL_W'(q_entry.yaw_n)   * MUL_W'(YAW_RECIP);
      pitch_mul = MUL_W'(q_entry.pitch_n) * MUL_W'(PITCH_RECIP);
      roll_mul  = MUL_W'(q_entry.roll_n)  * MUL_W'(ROLL_RECIP);
      s1_thr_in   = thr_mul[RECIP_SHIFT +: QUOT_W];
      s1_yaw_in   = yaw_mul[RECIP_SHIFT +: QUOT_W];
      s1_pitch_in = pitch_mul[RECIP_SHIFT +: QUOT_W];
      s1_roll_in  = roll_mul[RECIP_SHIFT +: QUOT_W];
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_thr_ff   <= s1_thr_in;
         s1_yaw_ff   <= s1_yaw_in;
         s1_pitch_ff <= s1_pitch_in;
         s1_roll_ff  <= s1_roll_in;
         s1_gyro_ff  <= q_entry.gyro;
      end
   end

   // stage 2: remove full scale, deadband and accumulate throttle
   always_comb begin
      att_full   = attitude_scale(cfg, s1_gyro_ff);
      thr_step   = $signed({1'b0, s1_thr_ff})   - $signed({2'b00, cfg.throttle_step_max});
      yaw_step   = $signed({1'b0, s1_yaw_ff})   - $signed({2'b00, cfg.yaw_rate_max});
      pitch_step = $signed({1'b0, s1_pitch_ff}) - $signed({2'b00, att_full});
      roll_step  = $signed({1'b0, s1_roll_ff})  - $signed({2'b00, att_full});
      thr_mag    = thr_step[STEP_W-1] ? -thr_step : thr_step;

      lim_milli = MILLI_W'(32'(cfg.throttle_limit) * MILLI_PER_UNIT);
      sum       = $signed({2'b00, milli_ff});
      if (thr_mag > $signed({{(STEP_W - DB_W){1'b0}}, cfg.throttle_deadband})) begin
         sum = sum + {{(SUM_W - STEP_W){thr_step[STEP_W-1]}}, thr_step};
      end
      if (sum[SUM_W-1]) begin
         milli_in = '0;
      end else if (sum[SUM_W-2:0] > {1'b0, lim_milli}) begin
         milli_in = lim_milli;
      end else begin
         milli_in = sum[MILLI_W-1:0];
      end

      s2_yaw_in   = yaw_step[CMD_W-1:0];
      s2_pitch_in = pitch_step[CMD_W-1:0];
      s2_roll_in  = roll_step[CMD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         s2_yaw_ff   <= s2_yaw_in;
         s2_pitch_ff <= s2_pitch_in;
         s2_roll_ff  <= s2_roll_in;
         s2_milli_ff <= milli_in;
         s2_gyro_ff  <= s1_gyro_ff;
      end
   end

   // stage 3: whole throttle units, result register
   always_comb begin
      thou_mul  = THOU_MUL_W'(s2_milli_ff) * THOU_MUL_W'(THOU_RECIP);
      s3_thr_in = thou_mul[THOU_SHIFT +: THR_CMD_W];
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         s3_thr_ff   <= s3_thr_in;
         s3_yaw_ff   <= s2_yaw_ff;
         s3_pitch_ff <= s2_pitch_ff;
         s3_roll_ff  <= s2_roll_ff;
         s3_gyro_ff  <= s2_gyro_ff;
      end
   end

   assign rsp_valid        = s3_valid_ff;
   assign rsp_throttle_cmd = s3_thr_ff;
   assign rsp_yaw_cmd      = s3_yaw_ff;
   assign rsp_pitch_cmd    = s3_pitch_ff;
   assign rsp_roll_cmd     = s3_roll_ff;
   assign rsp_gyro_mode    = s3_gyro_ff;

endmodule

[design/stick_command_conditioner.sv]
// ----------------------------------------------------------------------------
// stick_command_conditioner: stick samples to flight commands
// Throughput: one item per cycle while rsp_stall is low, set by the
// three-stage command pipeline; a 4-entry queue and the stage registers
// absorb output stalls. Each input is queued, then registered by stages 1-3.
// Reset: synchronous; restores register defaults, clears the throttle
// accumulator, selects angle mode with the button released; no clearing pass.
// ----------------------------------------------------------------------------
module stick_command_conditioner
   import scc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RAW_W-1:0]         req_throttle_stick,
   input  logic [RAW_W-1:0]         req_yaw_stick,
   input  logic [RAW_W-1:0]         req_pitch_stick,
   input  logic [RAW_W-1:0]         req_roll_stick,
   input  logic                     req_button_first,
   input  logic                     req_button_recheck,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [THR_CMD_W-1:0]     rsp_throttle_cmd,
   output logic signed [CMD_W-1:0]  rsp_yaw_cmd,
   output logic signed [CMD_W-1:0]  rsp_pitch_cmd,
   output logic signed [CMD_W-1:0]  rsp_roll_cmd,
   output logic                     rsp_gyro_mode,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   entry_type        front_entry, q_entry;
   front_status_type front_status;
   queue_status_type queue_status;
   logic             req_accept, q_pop;

   assign csr_ready  = 1'b1;
   assign req_stall  = queue_status.full;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_THROTTLE_STEP_MAX: cfg_in.throttle_step_max = csr_wdata[FULL_W-1:0];
            REG_THROTTLE_DEADBAND: cfg_in.throttle_deadband = csr_wdata[DB_W-1:0];
            REG_THROTTLE_LIMIT:    cfg_in.throttle_limit    = csr_wdata[FULL_W-1:0];
            REG_YAW_RATE_MAX:      cfg_in.yaw_rate_max      = csr_wdata[FULL_W-1:0];
            REG_ROLL_RATE_MAX:     cfg_in.roll_rate_max     = csr_wdata[FULL_W-1:0];
            REG_ROLL_ANGLE_MAX:    cfg_in.roll_angle_max    = csr_wdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_step_max <= RST_THROTTLE_STEP_MAX;
         cfg_ff.throttle_deadband <= RST_THROTTLE_DEADBAND;
         cfg_ff.throttle_limit    <= RST_THROTTLE_LIMIT;
         cfg_ff.yaw_rate_max      <= RST_YAW_RATE_MAX;
         cfg_ff.roll_rate_max     <= RST_ROLL_RATE_MAX;
         cfg_ff.roll_angle_max    <= RST_ROLL_ANGLE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .accept         (req_accept),
      .throttle_stick (req_throttle_stick),
      .yaw_stick      (req_yaw_stick),
      .pitch_stick    (req_pitch_stick),
      .roll_stick     (req_roll_stick),
      .button_first   (req_button_first),
      .button_recheck (req_button_recheck),
      .entry          (front_entry),
      .status         (front_status)
   );

   scc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (front_entry),
      .pop        (q_pop),
      .pop_entry  (q_entry),
      .status     (queue_status)
   );

   scc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (!queue_status.empty),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_throttle_cmd (rsp_throttle_cmd),
      .rsp_yaw_cmd      (rsp_yaw_cmd),
      .rsp_pitch_cmd    (rsp_pitch_cmd),
      .rsp_roll_cmd     (rsp_roll_cmd),
      .rsp_gyro_mode    (rsp_gyro_mode)
   );

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline or queue not empty after reset");

   a_mode_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(front_status))
      else $error("button state changed without an input transfer");

   a_queue_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept && queue_status.empty |=> !queue_status.empty)
      else $error("transfer into empty queue was lost");

endmodule
